>>> hw/rtl/kclk_pkg.sv
// ----------------------------------------------------------------------------
// kclk_pkg
// Shared types and constants for the keypad code entry lock: the request and
// response words, command and key codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package kclk_pkg;

   // Default number of digit positions in one code.
   localparam int CODE_LENGTH_DEF = 4;

   // Number of positions that have a configured code digit.
   localparam int NUM_CODE_REGS = 4;

   // Commands carried in a request word.
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_KEY   = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // Key codes with a special meaning.
   localparam logic [3:0] KEY_DIGIT_MIN = 4'd1;
   localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
   localparam logic [3:0] KEY_STAR      = 4'd10;
   localparam logic [3:0] KEY_ZERO      = 4'd11;
   localparam logic [3:0] KEY_HASH      = 4'd12;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_CODE_FIRST  = 3'd0;
   localparam logic [2:0] CSR_CODE_SECOND = 3'd1;
   localparam logic [2:0] CSR_CODE_THIRD  = 3'd2;
   localparam logic [2:0] CSR_CODE_FOURTH = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT     = 3'd4;

   // Register reset values.
   localparam logic [3:0] CODE_FIRST_RST  = 4'd1;
   localparam logic [3:0] CODE_SECOND_RST = 4'd2;
   localparam logic [3:0] CODE_THIRD_RST  = 4'd3;
   localparam logic [3:0] CODE_FOURTH_RST = 4'd4;
   localparam logic [7:0] TIMEOUT_RST     = 8'd10;

   // Saturation value of the seconds counter.
   localparam logic [7:0] SECONDS_MAX = 8'hFF;

   typedef struct packed {
      logic [1:0] cmd;
      logic [3:0] key_code;
   } req_word_type;

   typedef struct packed {
      logic [3:0] led_mask;
      logic       session_active;
      logic       session_done;
      logic       code_ok;
      logic       timed_out;
   } rsp_word_type;

endpackage

>>> hw/rtl/keypad_code_entry_lock_unit.sv
// ----------------------------------------------------------------------------
// keypad_code_entry_lock_unit
// Code entry session for a keypad combination lock: digit entry, step back,
// confirm with hash, compare against the configured code and time out.
// ----------------------------------------------------------------------------
// Usage:
// Request words (start, key press, one-second tick) enter on req_valid /
// req_stall; one response word leaves for every request on rsp_valid /
// rsp_stall. The configuration port (csr_valid / csr_ready, csr_index,
// csr_wdata) writes the four code digits and the timeout; it is always ready
// and is meant to be written only while no request is in flight.
// A request taken at a clock edge is held in the input register, and its response
// is loaded into the output register when that word moves on, which a stalled
// output can delay. The session update is one pass of short logic between
// the two registers, so one word is taken every cycle while the output moves.
// When the receiver stalls, the output word holds, the input register keeps
// one further word, and req_stall rises only while both are occupied.
// A synchronous reset empties both registers, ends any session, clears the
// stored digits and the seconds count, and restores the default code 1-2-3-4
// with a ten-second timeout.
// ----------------------------------------------------------------------------
module keypad_code_entry_lock_unit #(
   parameter int CODE_LENGTH = kclk_pkg::CODE_LENGTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  kclk_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output kclk_pkg::rsp_word_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [7:0]             csr_wdata
);
   import kclk_pkg::*;

   // Positions that are stored and compared; later ones only count.
   localparam int STORED = (CODE_LENGTH < NUM_CODE_REGS) ? CODE_LENGTH : NUM_CODE_REGS;
   localparam int FILL_W = $clog2(CODE_LENGTH + 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(CODE_LENGTH);

   // Configuration registers.
   logic [3:0] code_ff [NUM_CODE_REGS];
   logic [7:0] timeout_ff;

   // Session state.
   logic              active_ff, active_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [3:0]        digits_ff [STORED];
   logic [3:0]        digits_in [STORED];
   logic [7:0]        seconds_ff, seconds_in;

   // Input and output registers.
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         out_valid_ff;
   rsp_word_type out_word_ff, out_word_in;

   logic advance;
   logic [7:0] seconds_inc;
   logic match;
   logic is_digit;

   // The input register moves on when the output register is free or leaving.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;
   assign csr_ready = 1'b1;

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff[0] <= CODE_FIRST_RST;
         code_ff[1] <= CODE_SECOND_RST;
         code_ff[2] <= CODE_THIRD_RST;
         code_ff[3] <= CODE_FOURTH_RST;
         timeout_ff <= TIMEOUT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CODE_FIRST:  code_ff[0] <= csr_wdata[3:0];
            CSR_CODE_SECOND: code_ff[1] <= csr_wdata[3:0];
            CSR_CODE_THIRD:  code_ff[2] <= csr_wdata[3:0];
            CSR_CODE_FOURTH: code_ff[3] <= csr_wdata[3:0];
            CSR_TIMEOUT:     timeout_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Input register: loads whenever it is empty or its word moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!in_valid_ff || advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_valid_ff || advance) begin
         in_word_ff <= req_data;
      end
   end

   // Saturating seconds count and the code comparison.
   always_comb begin
      seconds_inc = (seconds_ff < SECONDS_MAX) ? seconds_ff + 8'd1 : seconds_ff;
      match = 1'b1;
      for (int i = 0; i < STORED; i++) begin
         if (digits_ff[i] != code_ff[i]) begin
            match = 1'b0;
         end
      end
      is_digit = (in_word_ff.key_code inside {[KEY_DIGIT_MIN:KEY_DIGIT_MAX]})
                 || (in_word_ff.key_code == KEY_ZERO);
   end

   // Session update for the word in the input register.
   always_comb begin
      active_in   = active_ff;
      fill_in     = fill_ff;
      seconds_in  = seconds_ff;
      digits_in   = digits_ff;
      out_word_in = '0;

      case (in_word_ff.cmd)
         CMD_START: begin
            active_in  = 1'b1;
            fill_in    = '0;
            seconds_in = '0;
         end
         CMD_KEY: begin
            if (active_ff) begin
               if (is_digit) begin
                  if (fill_ff < FILL_FULL) begin
                     for (int i = 0; i < STORED; i++) begin
                        if (fill_ff == FILL_W'(i)) begin
                           digits_in[i] = in_word_ff.key_code;
                        end
                     end
                     fill_in = fill_ff + FILL_W'(1);
                  end
               end else if (in_word_ff.key_code == KEY_STAR) begin
                  if (fill_ff != '0) begin
                     fill_in = fill_ff - FILL_W'(1);
                  end
               end else if (in_word_ff.key_code == KEY_HASH) begin
                  if (fill_ff == FILL_FULL) begin
                     out_word_in.session_done = 1'b1;
                     out_word_in.code_ok      = match;
                     active_in                = 1'b0;
                     fill_in                  = '0;
                  end
               end
            end
         end
         CMD_TICK: begin
            if (active_ff) begin
               seconds_in = seconds_inc;
               if (seconds_inc >= timeout_ff) begin
                  out_word_in.session_done = 1'b1;
                  out_word_in.timed_out    = 1'b1;
                  active_in                = 1'b0;
                  fill_in                  = '0;
                  for (int i = 0; i < STORED; i++) begin
                     digits_in[i] = '0;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // Thermometer of filled positions, shown only while a session runs.
      out_word_in.session_active = active_in;
      for (int i = 0; i < 4; i++) begin
         out_word_in.led_mask[i] = active_in && (int'(fill_in) > i);
      end
   end

   // Session state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         fill_ff    <= '0;
         seconds_ff <= '0;
         for (int i = 0; i < STORED; i++) begin
            digits_ff[i] <= '0;
         end
      end else if (advance) begin
         active_ff  <= active_in;
         fill_ff    <= fill_in;
         seconds_ff <= seconds_in;
         digits_ff  <= digits_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

`ifndef SYNTHESIS
   // A finished session is never reported as still running.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.session_done |-> !rsp_data.session_active)
      else $error("session_done together with session_active");

   // A verdict only comes with the word that ends the session.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.code_ok || rsp_data.timed_out) |-> rsp_data.session_done)
      else $error("verdict without session_done");

   // The lamps are dark whenever no session runs.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.session_active |-> rsp_data.led_mask == 4'd0)
      else $error("lamps lit while idle");

   // A stalled input means a word is held and the output cannot take it.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without cause");
`endif

endmodule
